@@ rtl/core/rcwc_pkg.sv @@
// ----------------------------------------------------------------------------
// Raycaster wall column projector: shared types and constants
// Register indexes, reset values, segment codes and the divider's sideband.
// ----------------------------------------------------------------------------
package rcwc_pkg;

    typedef enum logic [1:0] {
        REG_SCREEN_HEIGHT = 2'd0,
        REG_STRIP_WIDTH   = 2'd1,
        REG_TILE_SIZE     = 2'd2,
        REG_PROJ_DIST     = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        KIND_CEILING = 2'd0,
        KIND_WALL    = 2'd1,
        KIND_FLOOR   = 2'd2
    } seg_kind_t;

    localparam logic [10:0] SCREEN_HEIGHT_RESET = 11'd480;
    localparam logic [5:0]  STRIP_WIDTH_RESET   = 6'd1;
    localparam logic [7:0]  TILE_SIZE_RESET     = 8'd64;
    localparam logic [23:0] PROJ_DIST_RESET     = 24'd141891;

    // 0.1 in Q16.8.
    localparam logic [23:0] DIST_MIN = 24'd26;

    localparam logic [23:0] COLOR_CEILING = 24'h696969;
    localparam logic [23:0] COLOR_WALL    = 24'h373737;
    localparam logic [23:0] COLOR_FLOOR   = 24'h191919;

    localparam int NUM_W     = 40;
    localparam int DEN_W     = 24;
    localparam int QUOT_W    = 20;
    localparam int DIV_STAGES = 5;
    localparam int DIV_BITS  = 4;

    typedef struct packed {
        logic [15:0] x;
        logic        sat;
    } side_t;

endpackage

@@ rtl/core/raycast_wall_column_projector_unit.sv @@
// An accepted ray passes stages 0 to 9 into stage 10, the output holding
// register, which gives its ceiling beat, then one beat per cycle for wall
// and floor while out_ready is high. The 11-stage pipeline takes a ray a cycle,
// but halts until the floor beat, last of three on the single channel, is taken.
// Reset: all valid bits clear and the configuration registers return to their
// reset values; no clearing pass is needed, the cosine table being constant.
// ----------------------------------------------------------------------------
// Raycaster wall column projector
// Fisheye-corrects a ray's hit distance, projects the wall height and emits
// the ceiling, wall and floor segments of the ray's screen strip.
// ----------------------------------------------------------------------------
module raycast_wall_column_projector_unit #(
    parameter int ANGLE_BITS  = 12,
    parameter int MAX_COLUMNS = 2048
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [23:0]           cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [10:0]           column_index,
    input  logic [23:0]           ray_distance,
    input  logic [ANGLE_BITS-1:0] cast_angle,
    input  logic [ANGLE_BITS-1:0] view_angle,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [15:0]           x_start,
    output logic [1:0]            segment_kind,
    output logic [23:0]           segment_color,
    output logic [10:0]           y_start,
    output logic [10:0]           y_end,
    output logic                  last
);

    localparam logic [12:0]           MAX_COL = 13'(MAX_COLUMNS);
    localparam logic [ANGLE_BITS-2:0] QUARTER = (ANGLE_BITS-1)'(1 << (ANGLE_BITS - 2));

    // Configuration registers.
    logic [10:0] screen_height_reg;
    logic [5:0]  strip_width_reg;
    logic [7:0]  tile_size_reg;
    logic [23:0] proj_dist_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_height_reg <= rcwc_pkg::SCREEN_HEIGHT_RESET;
            strip_width_reg   <= rcwc_pkg::STRIP_WIDTH_RESET;
            tile_size_reg     <= rcwc_pkg::TILE_SIZE_RESET;
            proj_dist_reg     <= rcwc_pkg::PROJ_DIST_RESET;
        end
        else if (cfg_valid)
        begin
            case (rcwc_pkg::reg_index_t'(cfg_index))
                rcwc_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[10:0];
                rcwc_pkg::REG_STRIP_WIDTH:   strip_width_reg   <= cfg_data[5:0];
                rcwc_pkg::REG_TILE_SIZE:     tile_size_reg     <= cfg_data[7:0];
                rcwc_pkg::REG_PROJ_DIST:     proj_dist_reg     <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // The whole pipeline advances together; it halts only when the output
    // holding register cannot take the next ray.
    logic                    take;
    logic                    adv;
    logic                    hold_valid_reg;
    rcwc_pkg::seg_kind_t     kind_reg;

    assign take     = !hold_valid_reg
                      || (out_ready && kind_reg == rcwc_pkg::KIND_FLOOR);
    assign adv      = take;
    assign in_ready = take;

    // Stage 0: angle difference and cosine address.
    logic [ANGLE_BITS-1:0] diff;
    logic [1:0]            quad;
    logic [ANGLE_BITS-2:0] rom_addr;
    logic                  v0_reg;
    logic                  neg0_reg;
    logic [10:0]           col0_reg;
    logic [23:0]           dist0_reg;
    logic [ANGLE_BITS-2:0] addr0_reg;

    assign diff     = cast_angle - view_angle;
    assign quad     = diff[ANGLE_BITS-1:ANGLE_BITS-2];
    assign rom_addr = quad[0] ? (QUARTER - {1'b0, diff[ANGLE_BITS-3:0]})
                              : {1'b0, diff[ANGLE_BITS-3:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (adv)
            v0_reg <= in_valid && ({2'b00, column_index} < MAX_COL);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg0_reg  <= quad[1] ^ quad[0];
            col0_reg  <= column_index;
            dist0_reg <= ray_distance;
            addr0_reg <= rom_addr;
        end
    end

    // Stage 1: cosine read, strip position and numerator product.
    logic [16:0] mag1;
    logic        v1_reg;
    logic        neg1_reg;
    logic [23:0] dist1_reg;
    logic [15:0] x1_reg;
    logic [31:0] tp1_reg;
    logic [16:0] x_prod;

    rcwc_cos_rom #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cos_rom (
        .clk  (clk),
        .en   (adv),
        .addr (addr0_reg),
        .data (mag1)
    );

    assign x_prod = 17'(strip_width_reg) * 17'(col0_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg1_reg  <= neg0_reg;
            dist1_reg <= dist0_reg;
            x1_reg    <= x_prod[15:0];
            tp1_reg   <= 32'(tile_size_reg) * 32'(proj_dist_reg);
        end
    end

    // Stage 2: distance times cosine.
    logic        v2_reg;
    logic        neg2_reg;
    logic [15:0] x2_reg;
    logic [31:0] tp2_reg;
    logic [39:0] prod2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg2_reg  <= neg1_reg;
            x2_reg    <= x1_reg;
            tp2_reg   <= tp1_reg;
            prod2_reg <= 40'(dist1_reg) * 40'(mag1);
        end
    end

    // Stage 3: corrected distance, with the zero and negative cases forced
    // to the minimum distance.
    logic        v3_reg;
    logic [15:0] x3_reg;
    logic [39:0] num3_reg;
    logic [23:0] corr3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (adv)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x3_reg    <= x2_reg;
            num3_reg  <= {tp2_reg, 8'd0};
            corr3_reg <= (neg2_reg || prod2_reg[39:16] == 24'd0)
                         ? rcwc_pkg::DIST_MIN : prod2_reg[39:16];
        end
    end

    // Stage 4: a quotient of 2^19 or more is above any screen height.
    logic            v4_reg;
    rcwc_pkg::side_t side4_reg;
    logic [39:0]     num4_reg;
    logic [23:0]     corr4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (adv)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side4_reg.x   <= x3_reg;
            side4_reg.sat <= ({3'b000, num3_reg} >= {corr3_reg, 19'd0});
            num4_reg      <= num3_reg;
            corr4_reg     <= corr3_reg;
        end
    end

    // Stages 5 to 9: height quotient.
    logic            dv;
    logic [19:0]     quot;
    rcwc_pkg::side_t dside;

    rcwc_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v4_reg),
        .in_num    (num4_reg),
        .in_den    (corr4_reg),
        .in_side   (side4_reg),
        .out_valid (dv),
        .out_quot  (quot),
        .out_side  (dside)
    );

    // Stage 10: saturation and centring, into the output holding register.
    logic [18:0] hmax;
    logic [18:0] height;
    logic [19:0] up_sum;
    logic [10:0] up;
    logic [10:0] half;
    logic [10:0] top;
    logic [10:0] bottom;

    assign hmax   = {screen_height_reg, 8'd0};
    assign height = (dside.sat || quot > {1'b0, hmax}) ? hmax : quot[18:0];
    assign up_sum = {1'b0, height} + 20'd511;
    assign up     = up_sum[19:9];
    assign half   = {1'b0, screen_height_reg[10:1]};
    assign top    = (up > half) ? 11'd0 : half - up;
    assign bottom = half + {1'b0, height[18:9]};

    logic                hold_valid_next;
    rcwc_pkg::seg_kind_t kind_next;
    logic [15:0]         x_reg;
    logic [10:0]         top_reg;
    logic [10:0]         bottom_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        kind_next       = kind_reg;
        if (take)
        begin
            hold_valid_next = dv;
            kind_next       = rcwc_pkg::KIND_CEILING;
        end
        else if (out_ready)
        begin
            case (kind_reg)
                rcwc_pkg::KIND_CEILING: kind_next = rcwc_pkg::KIND_WALL;
                rcwc_pkg::KIND_WALL:    kind_next = rcwc_pkg::KIND_FLOOR;
                default:                kind_next = rcwc_pkg::KIND_CEILING;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            kind_reg       <= rcwc_pkg::KIND_CEILING;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            kind_reg       <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            x_reg      <= dside.x;
            top_reg    <= top;
            bottom_reg <= bottom;
        end
    end

    always_comb
    begin
        case (kind_reg)
            rcwc_pkg::KIND_CEILING:
            begin
                segment_color = rcwc_pkg::COLOR_CEILING;
                y_start       = 11'd0;
                y_end         = top_reg;
                last          = 1'b0;
            end
            rcwc_pkg::KIND_WALL:
            begin
                segment_color = rcwc_pkg::COLOR_WALL;
                y_start       = top_reg;
                y_end         = bottom_reg;
                last          = 1'b0;
            end
            default:
            begin
                segment_color = rcwc_pkg::COLOR_FLOOR;
                y_start       = bottom_reg;
                y_end         = screen_height_reg;
                last          = 1'b1;
            end
        endcase
    end

    assign out_valid    = hold_valid_reg;
    assign x_start      = x_reg;
    assign segment_kind = kind_reg;

    // A ceiling or wall beat that is taken is followed by the next segment.
    a_kind_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && segment_kind != rcwc_pkg::KIND_FLOOR
        |=> out_valid && segment_kind == $past(segment_kind) + 2'd1)
        else $error("segment order broken");

    // While the pipeline is halted the held ray does not change.
    a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> $stable(x_start) && $stable(top_reg) && $stable(bottom_reg))
        else $error("held ray changed while stalled");

    // The wall never starts below where it ends.
    a_wall_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && segment_kind == rcwc_pkg::KIND_WALL |-> y_start <= y_end)
        else $error("wall top below bottom");

endmodule

@@ rtl/core/rcwc_cos_rom.sv @@
// ----------------------------------------------------------------------------
// Quarter-wave cosine ROM
// Holds cos(k*pi/(2*Q)) in Q1.16 for k = 0..Q, built at elaboration from an
// eleven-term Taylor series, with a registered read.
// ----------------------------------------------------------------------------
module rcwc_cos_rom #(
    parameter int ANGLE_BITS = 12
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [ANGLE_BITS-2:0] addr,
    output logic [16:0]           data
);

    localparam int QUARTER = 1 << (ANGLE_BITS - 2);

    typedef logic [16:0] rom_t [QUARTER+1];

    function automatic longint unsigned term_div(input int n);
        case (n)
            1:       term_div = 64'd2;
            2:       term_div = 64'd12;
            3:       term_div = 64'd30;
            4:       term_div = 64'd56;
            5:       term_div = 64'd90;
            6:       term_div = 64'd132;
            7:       term_div = 64'd182;
            8:       term_div = 64'd240;
            9:       term_div = 64'd306;
            default: term_div = 64'd380;
        endcase
    endfunction

    // Shift-and-subtract quotient, used only while the table is built.
    function automatic longint unsigned long_div(input longint unsigned a,
                                                 input longint unsigned b);
        longint unsigned q;
        longint unsigned rm;
        q  = '0;
        rm = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rm = (rm << 1) | ((a >> i) & 64'd1);
            if (rm >= b)
            begin
                rm   = rm - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic rom_t build_rom();
        rom_t              r;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint            sum;
        longint unsigned   v;
        for (int k = 0; k <= QUARTER; k++)
        begin
            x = (64'(k) * 64'd3373259426 + (64'd1 << (ANGLE_BITS - 2)))
                >> (ANGLE_BITS - 1);
            x2 = (x * x) >> 30;
            term = 64'd1 << 30;
            sum = longint'(term);
            for (int n = 1; n <= 10; n++)
            begin
                term = (term * x2) >> 30;
                term = long_div(term, term_div(n));
                if ((n % 2) == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                r[k] = 17'd0;
            else
            begin
                v = (longint'(sum) + 64'd8192) >> 14;
                if (v > 64'd65536)
                    v = 64'd65536;
                r[k] = v[16:0];
            end
        end
        return r;
    endfunction

    localparam rom_t COS_ROM = build_rom();

    always_ff @(posedge clk)
    begin
        if (en)
            data <= COS_ROM[addr];
    end

endmodule

@@ rtl/core/rcwc_divider.sv @@
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Yields a 20-bit quotient over five stages of four bits each; the caller
// guarantees the quotient fits. Sideband and valid travel with the data.
// ----------------------------------------------------------------------------
module rcwc_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [rcwc_pkg::NUM_W-1:0] in_num,
    input  logic [rcwc_pkg::DEN_W-1:0] in_den,
    input  rcwc_pkg::side_t            in_side,
    output logic                       out_valid,
    output logic [rcwc_pkg::QUOT_W-1:0] out_quot,
    output rcwc_pkg::side_t            out_side
);

    localparam int STAGES = rcwc_pkg::DIV_STAGES;
    localparam int BITS   = rcwc_pkg::DIV_BITS;
    localparam int QW     = rcwc_pkg::QUOT_W;
    localparam int DW     = rcwc_pkg::DEN_W;
    localparam int REM_W  = DW + QW;

    logic [REM_W-1:0]      rem_reg   [STAGES-1];
    logic [QW-1:0]         quot_reg  [STAGES];
    logic [DW-1:0]         den_reg   [STAGES-1];
    rcwc_pkg::side_t       side_reg  [STAGES];
    logic                  valid_reg [STAGES];

    logic [REM_W-1:0]      rem_in    [STAGES];
    logic [QW-1:0]         quot_in   [STAGES];
    logic [DW-1:0]         den_in    [STAGES];
    rcwc_pkg::side_t       side_in   [STAGES];
    logic                  valid_in  [STAGES];

    genvar s;
    generate
        for (s = 0; s < STAGES; s++)
        begin : g_stage
            logic [REM_W-1:0] rem_next;
            logic [QW-1:0]    quot_next;

            if (s == 0)
            begin : g_first
                assign rem_in[s]   = REM_W'(in_num);
                assign quot_in[s]  = '0;
                assign den_in[s]   = in_den;
                assign side_in[s]  = in_side;
                assign valid_in[s] = in_valid;
            end
            else
            begin : g_next
                assign rem_in[s]   = rem_reg[s-1];
                assign quot_in[s]  = quot_reg[s-1];
                assign den_in[s]   = den_reg[s-1];
                assign side_in[s]  = side_reg[s-1];
                assign valid_in[s] = valid_reg[s-1];
            end

            always_comb
            begin
                logic [REM_W-1:0] trial;
                rem_next  = rem_in[s];
                quot_next = quot_in[s];
                for (int j = 0; j < BITS; j++)
                begin
                    trial = REM_W'(den_in[s]) << (QW - 1 - s * BITS - j);
                    if (rem_next >= trial)
                    begin
                        rem_next = rem_next - trial;
                        quot_next[QW - 1 - s * BITS - j] = 1'b1;
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[s] <= 1'b0;
                else if (en)
                    valid_reg[s] <= valid_in[s];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    quot_reg[s] <= quot_next;
                    side_reg[s] <= side_in[s];
                end
            end

            if (s < STAGES - 1)
            begin : g_keep
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[s] <= rem_next;
                        den_reg[s] <= den_in[s];
                    end
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[STAGES-1];
    assign out_quot  = quot_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule
